// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("crc8fpb check failed");

// Same, on the clk / rst_n of the enclosing module.
`define ASSERT_DEFAULT(label, prop) \
    `ASSERT_CLKRST(label, clk, rst_n, prop)

`endif

// ===== design/crc8fpb_pkg.sv =====
// Package: frame layout constants, payload types and the CRC-8 byte update.
package crc8fpb_pkg;

    typedef logic [7:0] byte_t;

    localparam int unsigned FRAME_LEN   = 12;
    localparam int unsigned PAYLOAD_LEN = 6;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned PAY_IDX_W   = 3;

    typedef logic [IDX_W-1:0] idx_t;

    // Fixed frame bytes
    localparam byte_t SYNC_1   = 8'h55;
    localparam byte_t SYNC_2   = 8'hAA;
    localparam byte_t LEN_BYTE = 8'h06;
    localparam byte_t TAIL_1   = 8'h0D;
    localparam byte_t TAIL_2   = 8'h0A;
    localparam byte_t CRC_POLY = 8'h8C;
    localparam byte_t CRC_INIT = 8'h00;

    // Byte positions inside the frame
    localparam idx_t POS_SYNC_2    = 4'd1;
    localparam idx_t POS_LEN       = 4'd2;
    localparam idx_t POS_PAY_FIRST = 4'd3;
    localparam idx_t POS_CRC       = 4'd9;
    localparam idx_t POS_TAIL_1    = 4'd10;
    localparam idx_t POS_TAIL_2    = 4'd11;

    // Six drive bytes, slot 0 is thrust_a
    typedef byte_t [PAYLOAD_LEN-1:0] drive_t;

    // Holding register contents handed to the serializer
    typedef struct packed {
        logic   valid;
        drive_t drive;
    } hold_t;

    // Reflected CRC-8, one byte: eight shift steps
    function automatic byte_t crc8_update(byte_t acc, byte_t data);
        byte_t r;
        r = acc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

// ===== design/crc8fpb_if.sv =====
// Channel interfaces: drive-byte input beat and frame-byte output beat.
interface crc8fpb_drive_if;
    logic       valid;
    logic       ready;
    logic [7:0] thrust_a;
    logic [7:0] thrust_b;
    logic [7:0] thrust_c;
    logic [7:0] thrust_d;
    logic [7:0] thrust_e;
    logic [7:0] thrust_f;

    modport source (output valid, thrust_a, thrust_b, thrust_c, thrust_d,
                    thrust_e, thrust_f, input ready);
    modport sink   (input valid, thrust_a, thrust_b, thrust_c, thrust_d,
                    thrust_e, thrust_f, output ready);
endinterface

interface crc8fpb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== design/crc8fpb_in_stage.sv =====
// Input holding register: takes a drive beat while the serializer is busy.
module crc8fpb_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    crc8fpb_drive_if.sink       drive,
    input  logic                take,
    output crc8fpb_pkg::hold_t  hold
);
    import crc8fpb_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    drive_t drive_reg;
    logic   accept;

    // Free slot, or the slot empties this cycle
    assign drive.ready = !valid_reg || take;
    assign accept      = drive.valid && drive.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg[0] <= drive.thrust_a;
            drive_reg[1] <= drive.thrust_b;
            drive_reg[2] <= drive.thrust_c;
            drive_reg[3] <= drive.thrust_d;
            drive_reg[4] <= drive.thrust_e;
            drive_reg[5] <= drive.thrust_f;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.drive = drive_reg;

endmodule

// ===== design/crc8fpb_serializer.sv =====
// Frame serializer: byte counter, running CRC and the output register.
module crc8fpb_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  crc8fpb_pkg::hold_t  hold,
    output logic                take,
    crc8fpb_frame_if.source     frame
);
    import crc8fpb_pkg::*;

    logic   busy_reg;
    idx_t   idx_reg;
    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_end_reg;
    byte_t  crc_reg;
    drive_t pay_reg;

    logic   advance;
    logic   start;
    logic   emit;
    idx_t   pay_off;
    byte_t  cur_byte;
    logic   last;

    // Output slot moves when empty or taken
    assign advance = !out_valid_reg || frame.ready;
    assign start   = advance && !busy_reg && hold.valid;
    assign emit    = advance && busy_reg;
    assign take    = start;
    assign last    = (idx_reg == POS_TAIL_2);
    assign pay_off = idx_reg - POS_PAY_FIRST;

    // Byte at the current frame position
    always_comb
    begin
        case (idx_reg)
            POS_SYNC_2: cur_byte = SYNC_2;
            POS_LEN:    cur_byte = LEN_BYTE;
            POS_CRC:    cur_byte = crc_reg;
            POS_TAIL_1: cur_byte = TAIL_1;
            POS_TAIL_2: cur_byte = TAIL_2;
            default:    cur_byte = pay_reg[pay_off[PAY_IDX_W-1:0]];
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg      <= 1'b1;
            idx_reg       <= POS_SYNC_2;
            out_valid_reg <= 1'b1;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= idx_reg + 1'b1;
            if (last)
                busy_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload, CRC and output data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pay_reg      <= hold.drive;
            out_byte_reg <= SYNC_1;
            out_end_reg  <= 1'b0;
            crc_reg      <= crc8_update(CRC_INIT, SYNC_1);
        end
        else if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= last;
            if (idx_reg < POS_CRC)
                crc_reg <= crc8_update(crc_reg, cur_byte);
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end  = out_end_reg;

endmodule

// ===== design/crc8_framed_packet_builder.sv =====
// Top level: six drive bytes in, 12-byte CRC-8 framed packet out.
//
// Usage:
//   drive : one beat carries thrust_a..thrust_f (valid/ready).
//   frame : one beat per frame byte, in transmit order: 0x55 0xAA 0x06,
//           the six drive bytes, the CRC-8 (reflected, poly 0x8C, init 0)
//           over the first nine bytes, then 0x0D 0x0A. frame_end is high on
//           the twelfth byte.
// A drive beat accepted while the serializer is idle is registered in the
//   holding register, then its first frame byte in the output register.
// Throughput: one frame byte per cycle while frame.ready is high; the
//   output port is the limit. Frames go out back to back with no gap.
// A one-beat holding register takes the next drive beat while the current
//   frame is still going out, so drive.ready stays high during a frame
//   until that next beat has been taken.
// Reset clears the holding register, the byte counter and the output
//   valid; no partial frame survives reset.
// When frame.ready is low the output byte holds and the frame pauses;
//   drive.ready drops once the holding register is full.
module crc8_framed_packet_builder (
    input  logic             clk,
    input  logic             rst_n,
    crc8fpb_drive_if.sink    drive,
    crc8fpb_frame_if.source  frame
);
    import crc8fpb_pkg::*;

    hold_t hold;
    logic  take;

    crc8fpb_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .drive (drive),
        .take  (take),
        .hold  (hold)
    );

    crc8fpb_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .hold  (hold),
        .take  (take),
        .frame (frame)
    );

endmodule

// ===== design/crc8fpb_checker.sv =====
// Port-level checker for the packet builder, bound to the top level.
`include "assert_macros.svh"

module crc8fpb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       frame_end
);
    import crc8fpb_pkg::*;

    // Stalled beat keeps its contents
    `ASSERT_DEFAULT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_end))

    // Last byte of a frame is the second trailer byte
    `ASSERT_DEFAULT(a_end_is_tail, out_valid && frame_end |-> frame_byte == TAIL_2)

    // A byte after a finished frame opens a new one
    `ASSERT_DEFAULT(a_new_frame_sync, out_valid && out_ready && frame_end |=> !out_valid || frame_byte == SYNC_1)

    // Inside a frame the bytes flow with no gap
    `ASSERT_DEFAULT(a_no_gap, out_valid && out_ready && !frame_end |=> out_valid)

endmodule

bind crc8_framed_packet_builder crc8fpb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .frame_byte (frame.frame_byte),
    .frame_end  (frame.frame_end)
);

// ===== verif/crc8fpb_frame_checker.sv =====
`timescale 1ns / 100ps
// Frame scoreboard: predicts each 12-byte frame from the drive beats and checks the output.
module crc8fpb_frame_checker
    import crc8fpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    crc8fpb_drive_if    drive,
    crc8fpb_frame_if    frame,
    output int unsigned fail_count,
    output int unsigned bytes_pending
);

    typedef struct packed {
        byte_t value;
        logic  last;
    } frame_beat_t;

    frame_beat_t expected_beats[$];
    frame_beat_t next_beat;
    int unsigned mismatches;
    int unsigned byte_pos;

    initial
    begin
        mismatches    = 0;
        bytes_pending = 0;
        byte_pos      = 0;
    end

    assign fail_count = mismatches;

    // Reflected CRC-8, fed one data bit at a time, LSB first
    function automatic byte_t crc_shift_byte(byte_t acc, byte_t data);
        byte_t r;
        logic  fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ data[i];
            r  = {1'b0, r[7:1]};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // Build the whole frame for one drive beat and queue its bytes
    function automatic void queue_frame(drive_t d);
        byte_t frame_bytes [FRAME_LEN];
        byte_t crc;
        frame_bytes[0]          = SYNC_1;
        frame_bytes[POS_SYNC_2] = SYNC_2;
        frame_bytes[POS_LEN]    = LEN_BYTE;
        for (int unsigned k = 0; k < PAYLOAD_LEN; k++)
            frame_bytes[POS_PAY_FIRST + k] = d[k];
        // check byte covers sync, length and payload
        crc = CRC_INIT;
        for (int unsigned k = 0; k < POS_CRC; k++)
            crc = crc_shift_byte(crc, frame_bytes[k]);
        frame_bytes[POS_CRC]    = crc;
        frame_bytes[POS_TAIL_1] = TAIL_1;
        frame_bytes[POS_TAIL_2] = TAIL_2;
        for (int unsigned k = 0; k < FRAME_LEN; k++)
            expected_beats.push_back('{frame_bytes[k], k == FRAME_LEN - 1});
    endfunction

    // Sample both channels at each edge; input side first so order is kept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            byte_pos      = 0;
            bytes_pending = 0;
        end
        else
        begin
            if (drive.valid && drive.ready)
                queue_frame({drive.thrust_f, drive.thrust_e, drive.thrust_d,
                             drive.thrust_c, drive.thrust_b, drive.thrust_a});

            if (frame.valid && frame.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected frame beat: got byte %h end %b",
                             $time, frame.frame_byte, frame.frame_end);
                end
                else
                begin
                    next_beat = expected_beats.pop_front();
                    if (next_beat.value !== frame.frame_byte ||
                        next_beat.last !== frame.frame_end)
                    begin
                        mismatches++;
                        $display("%0t: frame byte %0d: expected %h end %b, got %h end %b",
                                 $time, byte_pos, next_beat.value, next_beat.last,
                                 frame.frame_byte, frame.frame_end);
                    end
                end
                byte_pos = (byte_pos + 1) % FRAME_LEN;
            end

            bytes_pending = expected_beats.size();
        end
    end

endmodule

// ===== verif/tb_crc8_framed_packet_builder.sv =====
`timescale 1ns / 100ps
// Testbench top: drive-beat stimulus, output back-pressure and the final verdict.
module tb_crc8_framed_packet_builder;
    import crc8fpb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 91;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned HOLD_START   = 150;
    localparam int unsigned HOLD_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned bytes_pending;

    crc8fpb_drive_if drive_ch ();
    crc8fpb_frame_if frame_ch ();

    crc8_framed_packet_builder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .drive (drive_ch),
        .frame (frame_ch)
    );

    crc8fpb_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .drive         (drive_ch),
        .frame         (frame_ch),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offer one drive beat and hold it until accepted; valid stays high on return
    task automatic send_drive(input drive_t d);
        drive_ch.valid    <= 1'b1;
        drive_ch.thrust_a <= d[0];
        drive_ch.thrust_b <= d[1];
        drive_ch.thrust_c <= d[2];
        drive_ch.thrust_d <= d[3];
        drive_ch.thrust_e <= d[4];
        drive_ch.thrust_f <= d[5];
        do
            @(posedge clk);
        while (drive_ch.ready !== 1'b1);
    endtask

    task automatic pause_drive(input int unsigned n);
        drive_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random payload, leaning toward the all-zero and all-one bytes
    function automatic drive_t random_drive();
        drive_t d;
        for (int unsigned k = 0; k < PAYLOAD_LEN; k++)
        begin
            case ($urandom_range(0, 9))
                0:       d[k] = 8'h00;
                1:       d[k] = 8'hFF;
                default: d[k] = byte_t'($urandom_range(0, 255));
            endcase
        end
        return d;
    endfunction

    // Sender: directed beats back to back, then random bursts with gaps
    initial
    begin
        drive_t      d;
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        drive_ch.valid    <= 1'b0;
        drive_ch.thrust_a <= 8'h00;
        drive_ch.thrust_b <= 8'h00;
        drive_ch.thrust_c <= 8'h00;
        drive_ch.thrust_d <= 8'h00;
        drive_ch.thrust_e <= 8'h00;
        drive_ch.thrust_f <= 8'h00;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // extremes and sync-like payloads
        send_drive('0);
        send_drive('1);
        send_drive({PAYLOAD_LEN{SYNC_1}});
        send_drive({PAYLOAD_LEN{SYNC_2}});
        // one thruster at full scale, others off
        for (int unsigned f = 0; f < PAYLOAD_LEN; f++)
        begin
            d    = '0;
            d[f] = 8'hFF;
            send_drive(d);
        end
        // walking one across every byte
        for (int unsigned b = 0; b < 8; b++)
            send_drive({PAYLOAD_LEN{byte_t'(1 << b)}});
        // distinct byte per slot, catches swapped payload order
        for (int unsigned f = 0; f < PAYLOAD_LEN; f++)
            d[f] = byte_t'(8'h11 * (f + 1));
        send_drive(d);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 10);
            for (int unsigned i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_drive(random_drive());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
                pause_drive(gap);
        end
        drive_ch.valid <= 1'b0;

        // drain (the checker queues the last frame at its accepting edge),
        // then a short quiet tail to catch stray bytes
        do
            @(posedge clk);
        while (bytes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && bytes_pending == 0)
            $display("crc8_framed_packet_builder: match");
        else
            $display("crc8_framed_packet_builder: mismatch");
        $finish;
    end

    // Receiver: segments of varying stall density, plus one long hold-off
    initial
    begin
        int unsigned cyc;
        int unsigned seg_left;
        int unsigned stall_pct;
        int unsigned hold_left;

        frame_ch.ready <= 1'b0;
        cyc       = 0;
        seg_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end
            else
                frame_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("crc8_framed_packet_builder: mismatch");
        $finish;
    end

endmodule
